/* rtl/assert_macros.svh */
// Assertion macros shared by the vector normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/svn_pkg.sv */
// Package: widths, shared types and the output saturation function.
package svn_pkg;

  localparam int COMP_W         = 16;  // Q2.14 component
  localparam int SUM_W          = 35;  // Q7.28 sum of squares
  localparam int CNT_W          = 4;   // stored component count
  localparam int RAD_W          = 52;  // radicand: sum << 16, padded to even width
  localparam int ROOT_W         = RAD_W / 2;
  localparam int REM_W          = ROOT_W + 1;
  localparam int CU_W           = ROOT_W + 3;
  localparam int FRAC_SHIFT     = 22;
  localparam int NUM_W          = COMP_W + FRAC_SHIFT;
  localparam int QUO_W          = 17;
  localparam int STEP_W         = 5;
  localparam int VECTOR_LEN_DEF = 3;

  typedef struct packed {
    logic wr;     // store component and add its square
    logic clear;  // end of vector
  } acc_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } acc_stat_t;

  // Apply the sign and saturate the rounded quotient magnitude to Q2.14.
  function automatic logic [COMP_W-1:0] sat_q(input logic neg, input logic [QUO_W-1:0] q);
    logic [QUO_W-1:0] nq;
    nq = ~q + 1'b1;
    if (neg) begin
      if (q > QUO_W'(32768)) sat_q = 16'h8000;
      else sat_q = nq[COMP_W-1:0];
    end else begin
      if (q > QUO_W'(32767)) sat_q = 16'h7fff;
      else sat_q = q[COMP_W-1:0];
    end
  endfunction

endpackage

/* rtl/svn_cmpsub.sv */
// Shared compare-and-subtract unit used by the root and divide iterations.
module svn_cmpsub import svn_pkg::*; (
  input  logic [CU_W-1:0] a,
  input  logic [CU_W-1:0] b,
  output logic            ge,
  output logic [CU_W-1:0] diff
);

  logic [CU_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = ~full[CU_W];
  assign diff = full[CU_W-1:0];

endmodule

/* rtl/svn_accum.sv */
// Component store, running sum of squares and component count.
`include "assert_macros.svh"

module svn_accum import svn_pkg::*; #(
  parameter int VECTOR_LEN = VECTOR_LEN_DEF,
  parameter int IDX_W      = $clog2(VECTOR_LEN)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  acc_ctl_t                 ctl,
  input  logic signed [COMP_W-1:0] wr_data,
  input  logic [IDX_W-1:0]         rd_idx,
  output logic [COMP_W-1:0]        rd_data,
  output acc_stat_t                stat
);

  logic [COMP_W-1:0]  store_r [VECTOR_LEN];
  logic [COMP_W-1:0]  rd_data_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [31:0] sq;
  logic               room;

  assign room = count_r < CNT_W'(VECTOR_LEN);
  assign sq   = wr_data * wr_data;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    if (ctl.clear) begin
      count_nxt = '0;
      sum_nxt   = '0;
    end else if (ctl.wr && room) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + {{(SUM_W-31){1'b0}}, sq[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // drop components past the vector length
  always_ff @(posedge clk) begin
    if (ctl.wr && room && !ctl.clear) begin
      store_r[count_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= store_r[rd_idx];
  end

  assign rd_data    = rd_data_r;
  assign stat.count = count_r;
  assign stat.sum   = sum_r;

  `SVN_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(VECTOR_LEN), "count over length")
  `SVN_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctl.clear, count_r == '0 && sum_r == '0, "clear failed")

endmodule

/* rtl/spin_vector_normalize_unit.sv */
// A non-final component is taken and the unit stays ready for more. After the final
// component: a setup step, then for a nonzero sum 26 root steps and per result a divide
// load and 17 divide steps; input is refused until the last result enters the output
// register. Zero-norm vectors emit one result per cycle while the output is not stalled.
// One compare-subtract unit does every root and divide step. Synchronous active-low reset
// clears control, sum and count; the component store is not reset.
`include "assert_macros.svh"

module spin_vector_normalize_unit import svn_pkg::*; #(
  parameter int VECTOR_LEN = VECTOR_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COMP_W-1:0] in_component,
  input  logic                     in_last_component,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COMP_W-1:0] out_unit_component,
  output logic                     out_last_of_vector,
  output logic                     out_zero_norm
);

  localparam int IDX_W = $clog2(VECTOR_LEN);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_START  = 6'b000010,
    S_ROOT   = 6'b000100,
    S_DIVSET = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                zero_r, zero_nxt;
  logic                neg_r, neg_nxt;
  logic [RAD_W-1:0]    rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [QUO_W-1:0]    num_r, num_nxt;
  logic [QUO_W-1:0]    q_r, q_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [COMP_W-1:0]   out_comp_r, out_comp_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_zero_r, out_zero_nxt;

  acc_ctl_t            acc_ctl;
  acc_stat_t           acc_stat;
  logic [COMP_W-1:0]   rd_data;
  logic [COMP_W-1:0]   mag;
  logic [NUM_W-1:0]    num_full;
  logic [CU_W-1:0]     cu_a, cu_b, cu_diff;
  logic                cu_ge;
  logic                in_xfer, out_slot;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_slot = !out_valid_r || out_ready;

  // address the store with the next index; its read data is registered
  svn_accum #(.VECTOR_LEN(VECTOR_LEN), .IDX_W(IDX_W)) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .wr_data (in_component),
    .rd_idx  (idx_nxt[IDX_W-1:0]),
    .rd_data (rd_data),
    .stat    (acc_stat)
  );

  // root step: trial 4*root+1 against remainder with two new radicand bits;
  // divide step: root against remainder with one new numerator bit
  always_comb begin
    if (state_r == S_ROOT) begin
      cu_a = {rem_r, rad_r[RAD_W-1 -: 2]};
      cu_b = {1'b0, root_r, 2'b01};
    end else begin
      cu_a = {1'b0, rem_r, num_r[QUO_W-1]};
      cu_b = {3'b000, root_r};
    end
  end

  svn_cmpsub u_cmpsub (
    .a    (cu_a),
    .b    (cu_b),
    .ge   (cu_ge),
    .diff (cu_diff)
  );

  assign mag      = rd_data[COMP_W-1] ? (~rd_data + 1'b1) : rd_data;
  assign num_full = {mag, {FRAC_SHIFT{1'b0}}} + {{(NUM_W-ROOT_W+1){1'b0}}, root_r[ROOT_W-1:1]};

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    zero_nxt      = zero_r;
    neg_nxt       = neg_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_comp_nxt  = out_comp_r;
    out_last_nxt  = out_last_r;
    out_zero_nxt  = out_zero_r;
    acc_ctl.wr    = in_xfer;
    acc_ctl.clear = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_last_component) state_nxt = S_START;
      end
      S_START: begin
        n_nxt    = acc_stat.count;
        idx_nxt  = '0;
        zero_nxt = (acc_stat.sum == '0);
        rad_nxt  = {1'b0, acc_stat.sum, 16'h0000};
        rem_nxt  = '0;
        root_nxt = '0;
        step_nxt = '0;
        state_nxt = (acc_stat.sum == '0) ? S_OUT : S_ROOT;
      end
      S_ROOT: begin
        rem_nxt  = cu_ge ? cu_diff[REM_W-1:0] : cu_a[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], cu_ge};
        rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) state_nxt = S_DIVSET;
      end
      S_DIVSET: begin
        neg_nxt  = rd_data[COMP_W-1];
        rem_nxt  = {{(REM_W-NUM_W+QUO_W){1'b0}}, num_full[NUM_W-1:QUO_W]};
        num_nxt  = num_full[QUO_W-1:0];
        q_nxt    = '0;
        step_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = cu_ge ? cu_diff[REM_W-1:0] : cu_a[REM_W-1:0];
        q_nxt    = {q_r[QUO_W-2:0], cu_ge};
        num_nxt  = {num_r[QUO_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(QUO_W - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (out_slot) begin
          out_valid_nxt = 1'b1;
          out_comp_nxt  = zero_r ? '0 : sat_q(neg_r, q_r);
          out_last_nxt  = (idx_r + 1'b1 == n_r);
          out_zero_nxt  = zero_r;
          idx_nxt       = idx_r + 1'b1;
          if (idx_r + 1'b1 == n_r) begin
            acc_ctl.clear = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = zero_r ? S_OUT : S_DIVSET;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    num_r      <= num_nxt;
    q_r        <= q_nxt;
    out_comp_r <= out_comp_nxt;
    out_last_r <= out_last_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_unit_component = out_comp_r;
  assign out_last_of_vector = out_last_r;
  assign out_zero_norm      = out_zero_r;

  `SVN_ASSERT_NEXT(a_last_blocks_input, clk, rst_n, in_xfer && in_last_component, !in_ready, "input taken during vector end")
  `SVN_ASSERT_NOW(a_zero_gives_zero, clk, rst_n, out_valid_r && out_zero_r, out_comp_r == '0, "zero norm with nonzero result")
  `SVN_ASSERT_NOW(a_root_nonzero, clk, rst_n, state_r == S_DIV, root_r != '0, "divide by zero root")
  `SVN_ASSERT_NOW(a_idx_bound, clk, rst_n, state_r == S_DIVSET || state_r == S_OUT, idx_r < n_r, "result index past count")

endmodule

/* dv/spin_vector_normalize_unit_test.sv */
// Self-checking testbench for spin_vector_normalize_unit: random and directed vectors.
module spin_vector_normalize_unit_test import svn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VLEN = VECTOR_LEN_DEF;
  localparam int RANDOM_ITEMS = 200;

  typedef struct {
    logic signed [COMP_W-1:0] comp;
    logic                     last;
    logic                     zero;
  } unit_result_t;

  typedef enum {FILL_WIDE, FILL_NARROW, FILL_ZERO, FILL_EDGE} fill_t;

  // Predicts normalized components per vector and checks them in order.
  class unit_vector_board;
    logic signed [COMP_W-1:0] held [8];
    logic [SUM_W-1:0]         square_sum = '0;
    int                       held_count = 0;
    int                       seen_in_vector = 0;
    unit_result_t             expected_units [$];
    int mismatches = 0, units_checked = 0, vectors_closed = 0;
    int zero_vectors = 0, short_vectors = 0, long_vectors = 0;

    static function longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void note_component(logic signed [COMP_W-1:0] c, logic last);
      longint v, q;
      longint unsigned mag, root, quo;
      logic zero;
      unit_result_t u;
      seen_in_vector++;
      // drop components beyond the vector length
      if (held_count < VLEN) begin
        held[held_count] = c;
        v = c;
        mag = (v < 0) ? -v : v;
        square_sum = square_sum + SUM_W'(mag * mag);
        held_count++;
      end
      if (!last) return;
      zero = (square_sum == 0);
      root = zero ? 0 : int_root(longint'(square_sum) << 16);
      for (int k = 0; k < held_count; k++) begin
        v = held[k];
        q = 0;
        if (!zero && root != 0) begin
          mag = (v < 0) ? -v : v;
          quo = ((mag << 22) + (root >> 1)) / root;
          if (quo > 40000) quo = 40000;
          q = (v < 0) ? -longint'(quo) : longint'(quo);
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
        end
        u.comp = q[COMP_W-1:0];
        u.last = (k == held_count - 1);
        u.zero = zero;
        expected_units.push_back(u);
      end
      vectors_closed++;
      if (zero) zero_vectors++;
      if (seen_in_vector > VLEN) long_vectors++;
      else if (held_count < VLEN) short_vectors++;
      square_sum = '0;
      held_count = 0;
      seen_in_vector = 0;
    endfunction

    function void check_unit(logic signed [COMP_W-1:0] c, logic last, logic zero);
      unit_result_t e;
      if (expected_units.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, got comp=%0d last=%0b zero=%0b",
                 $time, c, last, zero);
        return;
      end
      e = expected_units.pop_front();
      units_checked++;
      if (e.comp !== c) begin
        mismatches++;
        $display("%0t: unit_component expected %0d, got %0d", $time, e.comp, c);
      end
      if (e.last !== last) begin
        mismatches++;
        $display("%0t: last_of_vector expected %0b, got %0b", $time, e.last, last);
      end
      if (e.zero !== zero) begin
        mismatches++;
        $display("%0t: zero_norm expected %0b, got %0b", $time, e.zero, zero);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [COMP_W-1:0] in_component = '0;
  logic                     in_last_component = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [COMP_W-1:0] out_unit_component;
  logic                     out_last_of_vector;
  logic                     out_zero_norm;

  unit_vector_board sb = new;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int out_stall_left = 0;
  bit quiet = 1'b0;
  int items_sent = 0;

  spin_vector_normalize_unit #(.VECTOR_LEN(VLEN)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_component      (in_component),
    .in_last_component (in_last_component),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_unit_component(out_unit_component),
    .out_last_of_vector(out_last_of_vector),
    .out_zero_norm     (out_zero_norm)
  );

  always #5 clk = ~clk;

  // Receiver drops ready in bursts whose length is drawn at random when a stall starts.
  always @(posedge clk) begin
    if (out_stall_left != 0) begin
      out_stall_left <= out_stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
      out_stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_unit(out_unit_component, out_last_of_vector, out_zero_norm);
  end

  task automatic send_component(logic signed [COMP_W-1:0] c, logic last);
    if (!quiet && in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_component <= c;
    in_last_component <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_component(c, last);
    items_sent++;
  endtask

  function automatic logic signed [COMP_W-1:0] pick_component(fill_t fill);
    case (fill)
      FILL_WIDE:   return COMP_W'($urandom);
      FILL_NARROW: return COMP_W'(int'($urandom_range(0, 64)) - 32);
      FILL_ZERO:   return '0;
      default: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic send_vector(int len, fill_t fill);
    for (int i = 0; i < len; i++) send_component(pick_component(fill), i == len - 1);
  endtask

  initial begin
    int start, roll, len;
    fill_t fill;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unit axis, extremes, zero vectors, short and overlong vectors
    send_component(16384, 1'b0); send_component(0, 1'b0); send_component(0, 1'b1);
    send_component(32767, 1'b0); send_component(32767, 1'b0); send_component(32767, 1'b1);
    send_component(-32768, 1'b0); send_component(-32768, 1'b0);
    send_component(-32768, 1'b1);
    send_component(0, 1'b0); send_component(0, 1'b0); send_component(0, 1'b1);
    send_component(-32768, 1'b1);
    send_component(1, 1'b0); send_component(-1, 1'b1);
    send_component(100, 1'b0); send_component(-200, 1'b0); send_component(300, 1'b0);
    send_component(400, 1'b0); send_component(-500, 1'b1);
    send_component(0, 1'b1);
    send_component(1, 1'b0); send_component(0, 1'b0); send_component(0, 1'b1);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: in_idle_pct = 0;
          1: in_idle_pct = 10;
          default: in_idle_pct = 35;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_pct = 0;
          1: out_stall_pct = 15;
          default: out_stall_pct = 50;
        endcase
      end
      // no idling or receiver stalls in the closing stretch
      quiet = (items_sent - start >= RANDOM_ITEMS * 85 / 100);
      roll = $urandom_range(0, 99);
      if (roll < 65) len = VLEN;
      else if (roll < 82) len = $urandom_range(1, VLEN - 1);
      else len = VLEN + $urandom_range(1, 3);
      roll = $urandom_range(0, 99);
      if (roll < 55) fill = FILL_WIDE;
      else if (roll < 75) fill = FILL_NARROW;
      else if (roll < 88) fill = FILL_EDGE;
      else fill = FILL_ZERO;
      send_vector(len, fill);
    end
    in_valid <= 1'b0;
    quiet = 1'b1;

    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d components in %0d vectors (%0d zero-norm, %0d short, %0d overlong).",
             items_sent, sb.vectors_closed, sb.zero_vectors, sb.short_vectors,
             sb.long_vectors);
    $display("Compared %0d normalized components, %0d mismatches.",
             sb.units_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", sb.expected_units.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/svn_pkg.sv
rtl/svn_cmpsub.sv
rtl/svn_accum.sv
rtl/spin_vector_normalize_unit.sv
dv/spin_vector_normalize_unit_test.sv
